[src/tap_code_lock_top_defines.svh]
// ---------------------------------------------------------------------------
// tap code lock assertion macros
// shared concurrent assertion wrappers for the checker
// ---------------------------------------------------------------------------
`ifndef TAP_CODE_LOCK_TOP_DEFINES_SVH
`define TAP_CODE_LOCK_TOP_DEFINES_SVH

// clocked assertion, disabled while reset is asserted
`define TCL_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// same cycle implication
`define TCL_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   `TCL_ASSERT(lbl, clk, rst, (ante) |-> (cons), msg)

// next cycle implication
`define TCL_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   `TCL_ASSERT(lbl, clk, rst, (ante) |=> (cons), msg)

`endif

[src/tcl_pkg.sv]
// ---------------------------------------------------------------------------
// tap code lock package
// constants, register codes and shared types of the tap code lock
// ---------------------------------------------------------------------------
`default_nettype none

package tcl_pkg;

   localparam int NUM_WINDOWS   = 3;
   localparam int LAST_WINDOW   = NUM_WINDOWS - 1;
   localparam int EARLIER_DEPTH = 2;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   localparam logic [3:0] TAP_MAX       = 4'd15;
   localparam logic [1:0] WINDOW_DONE   = 2'd3;
   localparam logic [1:0] WINDOW_FINAL  = 2'(NUM_WINDOWS);

   localparam logic [3:0]  RESET_DIGIT_FIRST      = 4'd5;
   localparam logic [3:0]  RESET_DIGIT_SECOND     = 4'd2;
   localparam logic [3:0]  RESET_DIGIT_THIRD      = 4'd3;
   localparam logic [15:0] RESET_TICKS_PER_SECOND = 16'd200;
   localparam logic [3:0]  RESET_WINDOW_SECONDS   = 4'd5;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_DIGIT_FIRST,
      CSR_DIGIT_SECOND,
      CSR_DIGIT_THIRD,
      CSR_TICKS_PER_SECOND,
      CSR_WINDOW_SECONDS
   } csr_index_type;

   typedef struct packed {
      logic [2:0][3:0] digit;
      logic [15:0]     ticks_per_second;
      logic [3:0]      window_seconds;
   } cfg_type;

   typedef struct packed {
      logic       window_end;
      logic [3:0] countdown;
   } timer_status_type;

   typedef struct packed {
      logic       finished;
      logic [1:0] window_index;
      logic       verdict;
   } tally_status_type;

endpackage

`default_nettype wire

[src/tcl_timer.sv]
// ---------------------------------------------------------------------------
// tap code lock timer
// tick and second counters of the current window, countdown digit
// ---------------------------------------------------------------------------
`default_nettype none

module tcl_timer (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      step,
   input  wire tcl_pkg::cfg_type          cfg,
   output      tcl_pkg::timer_status_type status
);

   logic [15:0] tick_ff, tick_in;
   logic [3:0]  second_ff, second_in;
   logic [16:0] tick_next;
   logic [4:0]  second_next;
   logic        second_end;
   logic        window_end;

   assign tick_next   = {1'b0, tick_ff} + 17'd1;
   assign second_next = {1'b0, second_ff} + 5'd1;
   // a zero tick count ends the second on every tick, a zero window length ends the window at every second's end
   assign second_end  = tick_next >= {1'b0, cfg.ticks_per_second};
   assign window_end  = second_end && (second_next >= {1'b0, cfg.window_seconds});

   always_comb begin
      tick_in   = tick_ff;
      second_in = second_ff;
      if (step) begin
         if (second_end) begin
            tick_in   = '0;
            second_in = window_end ? 4'd0 : second_next[3:0];
         end else begin
            tick_in = tick_next[15:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff   <= '0;
         second_ff <= '0;
      end else begin
         tick_ff   <= tick_in;
         second_ff <= second_in;
      end
   end

   assign status.window_end = window_end;
   assign status.countdown  = (cfg.window_seconds > second_ff) ?
                              (cfg.window_seconds - second_ff) : 4'd0;

endmodule

`default_nettype wire

[src/tcl_tally.sv]
// ---------------------------------------------------------------------------
// tap code lock tally
// tap edge counting per window, window sequencing and final verdict
// ---------------------------------------------------------------------------
`default_nettype none

module tcl_tally (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      step,
   input  wire logic                      touch,
   input  wire logic                      window_end,
   input  wire tcl_pkg::cfg_type          cfg,
   output      tcl_pkg::tally_status_type status
);

   logic [1:0] window_ff, window_in;
   logic       held_ff, held_in;
   logic [3:0] tap_ff, tap_in;
   logic [3:0] earlier_ff [tcl_pkg::EARLIER_DEPTH];
   logic [3:0] earlier_in [tcl_pkg::EARLIER_DEPTH];
   logic       verdict_ff, verdict_in;
   logic       tap_bump;
   logic [3:0] tap_next;
   logic       match;

   assign tap_bump = touch && !held_ff && (tap_ff != tcl_pkg::TAP_MAX);
   assign tap_next = tap_ff + {3'd0, tap_bump};

   // this tick's tap already counts towards the last window
   always_comb begin
      match = (tap_next == cfg.digit[tcl_pkg::LAST_WINDOW]);
      for (int k = 0; k < tcl_pkg::EARLIER_DEPTH; k++) begin
         if ((k < tcl_pkg::LAST_WINDOW) && (earlier_ff[k] != cfg.digit[k])) begin
            match = 1'b0;
         end
      end
   end

   always_comb begin
      window_in  = window_ff;
      held_in    = held_ff;
      tap_in     = tap_ff;
      earlier_in = earlier_ff;
      verdict_in = verdict_ff;
      if (step) begin
         tap_in  = tap_next;
         held_in = touch;
         if (window_end) begin
            tap_in  = '0;
            held_in = 1'b0;
            if (window_ff < 2'(tcl_pkg::LAST_WINDOW)) begin
               if (window_ff < 2'(tcl_pkg::EARLIER_DEPTH)) begin
                  earlier_in[window_ff[0]] = tap_next;
               end
               window_in = window_ff + 2'd1;
            end else begin
               verdict_in = match;
               window_in  = tcl_pkg::WINDOW_FINAL;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff  <= '0;
         held_ff    <= 1'b0;
         tap_ff     <= '0;
         verdict_ff <= 1'b0;
         for (int k = 0; k < tcl_pkg::EARLIER_DEPTH; k++) begin
            earlier_ff[k] <= '0;
         end
      end else begin
         window_ff  <= window_in;
         held_ff    <= held_in;
         tap_ff     <= tap_in;
         verdict_ff <= verdict_in;
         earlier_ff <= earlier_in;
      end
   end

   assign status.finished     = window_ff >= tcl_pkg::WINDOW_FINAL;
   assign status.window_index = window_ff;
   assign status.verdict      = verdict_ff;

endmodule

`default_nettype wire

[src/tap_code_lock_top.sv]
// ---------------------------------------------------------------------------
// tap code lock top level
// three timed tap-counting windows checked against a stored combination
// ---------------------------------------------------------------------------
// One touch sample enters per transaction and produces exactly one result
// transaction. A new sample can be taken every cycle; its result is held in
// the output register and appears on the cycle after acceptance, and the
// input keeps accepting while that register is free or being emptied in the
// same cycle. The result shows the countdown, window and verdict as they
// stood before the sample was applied, so the verdict appears on the
// transaction after the last window ends and then stays until reset.
// Configuration writes take effect on the following cycle.
`default_nettype none

module tap_code_lock_top (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_we,
   input  wire logic [tcl_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [tcl_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  wire logic                              req_valid,
   output      logic                              req_ready,
   input  wire logic                              req_touch,
   output      logic                              rsp_valid,
   input  wire logic                              rsp_ready,
   output      logic                              rsp_led_on,
   output      logic [3:0]                        rsp_countdown,
   output      logic [1:0]                        rsp_window_index,
   output      logic                              rsp_verdict_valid,
   output      logic                              rsp_unlocked
);

   tcl_pkg::cfg_type          cfg_ff, cfg_in;
   tcl_pkg::timer_status_type timer_status;
   tcl_pkg::tally_status_type tally_status;

   logic       req_accept;
   logic       step;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       led_ff, led_in;
   logic [3:0] countdown_ff, countdown_in;
   logic [1:0] window_ff, window_in;
   logic       verdict_valid_ff, verdict_valid_in;
   logic       unlocked_ff, unlocked_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (tcl_pkg::csr_index_type'(csr_index))
            tcl_pkg::CSR_DIGIT_FIRST:      cfg_in.digit[0] = csr_wdata[3:0];
            tcl_pkg::CSR_DIGIT_SECOND:     cfg_in.digit[1] = csr_wdata[3:0];
            tcl_pkg::CSR_DIGIT_THIRD:      cfg_in.digit[2] = csr_wdata[3:0];
            tcl_pkg::CSR_TICKS_PER_SECOND: cfg_in.ticks_per_second = csr_wdata;
            tcl_pkg::CSR_WINDOW_SECONDS:   cfg_in.window_seconds = csr_wdata[3:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.digit[0]         <= tcl_pkg::RESET_DIGIT_FIRST;
         cfg_ff.digit[1]         <= tcl_pkg::RESET_DIGIT_SECOND;
         cfg_ff.digit[2]         <= tcl_pkg::RESET_DIGIT_THIRD;
         cfg_ff.ticks_per_second <= tcl_pkg::RESET_TICKS_PER_SECOND;
         cfg_ff.window_seconds   <= tcl_pkg::RESET_WINDOW_SECONDS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign req_accept = req_valid && req_ready;
   // counters freeze once the verdict is in
   assign step       = req_accept && !tally_status.finished;

   tcl_timer u_timer (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .cfg    (cfg_ff),
      .status (timer_status)
   );

   tcl_tally u_tally (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .touch      (req_touch),
      .window_end (timer_status.window_end),
      .cfg        (cfg_ff),
      .status     (tally_status)
   );

   always_comb begin
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      led_in           = led_ff;
      countdown_in     = countdown_ff;
      window_in        = window_ff;
      verdict_valid_in = verdict_valid_ff;
      unlocked_in      = unlocked_ff;
      if (req_accept) begin
         rsp_valid_in = 1'b1;
         led_in       = req_touch;
         if (tally_status.finished) begin
            countdown_in     = 4'd0;
            window_in        = tcl_pkg::WINDOW_DONE;
            verdict_valid_in = 1'b1;
            unlocked_in      = tally_status.verdict;
         end else begin
            countdown_in     = timer_status.countdown;
            window_in        = tally_status.window_index;
            verdict_valid_in = 1'b0;
            unlocked_in      = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      led_ff           <= led_in;
      countdown_ff     <= countdown_in;
      window_ff        <= window_in;
      verdict_valid_ff <= verdict_valid_in;
      unlocked_ff      <= unlocked_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_led_on        = led_ff;
   assign rsp_countdown     = countdown_ff;
   assign rsp_window_index  = window_ff;
   assign rsp_verdict_valid = verdict_valid_ff;
   assign rsp_unlocked      = unlocked_ff;

endmodule

`default_nettype wire

[src/tcl_checker.sv]
// ---------------------------------------------------------------------------
// tap code lock checker
// port-level assertions on the tap code lock, bound to the top level
// ---------------------------------------------------------------------------
`default_nettype none

`include "tap_code_lock_top_defines.svh"

module tcl_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic       req_touch,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic       rsp_led_on,
   input wire logic [3:0] rsp_countdown,
   input wire logic [1:0] rsp_window_index,
   input wire logic       rsp_verdict_valid,
   input wire logic       rsp_unlocked
);

   `TCL_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_led_on) && $stable(rsp_countdown) && $stable(rsp_window_index) && $stable(rsp_unlocked), "stalled result transaction changed")
   `TCL_ASSERT_NEXT(a_led_follows, clock, reset, req_valid && req_ready, rsp_valid && (rsp_led_on == $past(req_touch)), "result does not follow accepted transaction")
   `TCL_ASSERT_IMPLY(a_ready_free, clock, reset, !req_ready, rsp_valid && !rsp_ready, "input stalled while output register free")
   `TCL_ASSERT_IMPLY(a_done_shape, clock, reset, rsp_valid && rsp_verdict_valid, (rsp_window_index == 2'd3) && (rsp_countdown == 4'd0), "finished result with live window fields")
   `TCL_ASSERT_IMPLY(a_unlock_gated, clock, reset, rsp_valid && !rsp_verdict_valid, !rsp_unlocked && (rsp_window_index != 2'd3), "unlock shown before verdict")

endmodule

bind tap_code_lock_top tcl_checker u_tcl_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_ready         (req_ready),
   .req_touch         (req_touch),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_led_on        (rsp_led_on),
   .rsp_countdown     (rsp_countdown),
   .rsp_window_index  (rsp_window_index),
   .rsp_verdict_valid (rsp_verdict_valid),
   .rsp_unlocked      (rsp_unlocked)
);

`default_nettype wire

[tb/tb_tap_code_lock_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tap code lock testbench
// Drives touch samples through the request channel and checks every result
// transaction against a cycle-free model of the three counting windows, the
// countdown and the final verdict. Register settings change between phases
// while nothing is in flight, and both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_tap_code_lock_top;

   localparam int RESET_CYCLES   = 7;
   localparam int RANDOM_ITEMS   = 1110;
   localparam int CATCH_UP_SPAN  = 800;
   localparam int DRAIN_CYCLES   = 8;
   localparam int CYCLE_LIMIT    = 400000;
   localparam int SPARE_INDEX    = int'(tcl_pkg::CSR_WINDOW_SECONDS) + 1;
   localparam int TOP_INDEX      = (1 << tcl_pkg::CSR_INDEX_W) - 1;

   typedef struct packed {
      logic       led_on;
      logic [3:0] countdown;
      logic [1:0] window_index;
      logic       verdict_valid;
      logic       unlocked;
   } lock_view_type;

   logic                            clock     = 1'b0;
   logic                            reset     = 1'b1;
   logic                            csr_we    = 1'b0;
   logic [tcl_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [tcl_pkg::CSR_DATA_W-1:0]  csr_wdata = '0;
   logic                            req_valid = 1'b0;
   logic                            req_touch = 1'b0;
   logic                            rsp_ready = 1'b0;
   logic                            req_ready;
   logic                            rsp_valid;
   logic                            rsp_led_on;
   logic [3:0]                      rsp_countdown;
   logic [1:0]                      rsp_window_index;
   logic                            rsp_verdict_valid;
   logic                            rsp_unlocked;

   // lock model state
   tcl_pkg::cfg_type lock_cfg;
   logic [15:0]      tick_in_sec;
   logic [3:0]       sec_in_win;
   logic [1:0]       win_nr;
   logic             finger_held;
   logic [3:0]       taps;
   logic [3:0]       closed_taps [tcl_pkg::EARLIER_DEPTH];
   logic             verdict_bit;

   lock_view_type pending_views [$];
   int            failures = 0;
   int            cycles = 0;
   int            random_sent = 0;
   int            hold_off = 0;
   int            calm = 0;
   int            stall_roll;

   tap_code_lock_top u_dut (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_touch         (req_touch),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_led_on        (rsp_led_on),
      .rsp_countdown     (rsp_countdown),
      .rsp_window_index  (rsp_window_index),
      .rsp_verdict_valid (rsp_verdict_valid),
      .rsp_unlocked      (rsp_unlocked)
   );

   always #6 clock = ~clock;

   function automatic void clear_lock_model();
      lock_cfg.digit[0]         = tcl_pkg::RESET_DIGIT_FIRST;
      lock_cfg.digit[1]         = tcl_pkg::RESET_DIGIT_SECOND;
      lock_cfg.digit[2]         = tcl_pkg::RESET_DIGIT_THIRD;
      lock_cfg.ticks_per_second = tcl_pkg::RESET_TICKS_PER_SECOND;
      lock_cfg.window_seconds   = tcl_pkg::RESET_WINDOW_SECONDS;
      tick_in_sec    = '0;
      sec_in_win     = '0;
      win_nr         = '0;
      finger_held    = 1'b0;
      taps           = '0;
      closed_taps[0] = '0;
      closed_taps[1] = '0;
      verdict_bit    = 1'b0;
   endfunction

   function automatic void write_lock_cfg(input logic [tcl_pkg::CSR_INDEX_W-1:0] idx,
                                          input logic [tcl_pkg::CSR_DATA_W-1:0] data);
      case (idx)
         tcl_pkg::CSR_DIGIT_FIRST:      lock_cfg.digit[0] = data[3:0];
         tcl_pkg::CSR_DIGIT_SECOND:     lock_cfg.digit[1] = data[3:0];
         tcl_pkg::CSR_DIGIT_THIRD:      lock_cfg.digit[2] = data[3:0];
         tcl_pkg::CSR_TICKS_PER_SECOND: lock_cfg.ticks_per_second = data;
         tcl_pkg::CSR_WINDOW_SECONDS:   lock_cfg.window_seconds = data[3:0];
         default: ;
      endcase
   endfunction

   function automatic void close_window();
      if (int'(win_nr) < tcl_pkg::LAST_WINDOW) begin
         closed_taps[win_nr[0]] = taps;
         win_nr = win_nr + 1'b1;
      end else begin
         verdict_bit = (taps == lock_cfg.digit[2]) && (closed_taps[0] == lock_cfg.digit[0])
                       && (closed_taps[1] == lock_cfg.digit[1]);
         win_nr = tcl_pkg::WINDOW_FINAL;
      end
      taps        = '0;
      finger_held = 1'b0;
      sec_in_win  = '0;
   endfunction

   // result shows the state before the sample, then the sample is applied
   function automatic lock_view_type apply_touch(input logic t);
      lock_view_type v;
      v.led_on = t;
      if (win_nr == tcl_pkg::WINDOW_FINAL) begin
         v.countdown     = '0;
         v.window_index  = tcl_pkg::WINDOW_DONE;
         v.verdict_valid = 1'b1;
         v.unlocked      = verdict_bit;
         return v;
      end
      v.countdown     = (lock_cfg.window_seconds > sec_in_win)
                        ? lock_cfg.window_seconds - sec_in_win : '0;
      v.window_index  = win_nr;
      v.verdict_valid = 1'b0;
      v.unlocked      = 1'b0;
      if (t && !finger_held && taps != tcl_pkg::TAP_MAX)
         taps = taps + 1'b1;
      finger_held = t;
      if (32'(tick_in_sec) + 1 >= 32'(lock_cfg.ticks_per_second)) begin
         tick_in_sec = '0;
         if (32'(sec_in_win) + 1 >= 32'(lock_cfg.window_seconds))
            close_window();
         else
            sec_in_win = sec_in_win + 1'b1;
      end else begin
         tick_in_sec = tick_in_sec + 1'b1;
      end
      return v;
   endfunction

   function automatic void compare_field(input string label, input logic [3:0] want_v,
                                         input logic [3:0] got_v);
      if (want_v !== got_v) begin
         failures++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, label, want_v, got_v);
      end
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(99);
      if (r < 65) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 9);
      return $urandom_range(15, 40);
   endfunction

   // upper data bits are sometimes junk, the register keeps its low nibble
   function automatic logic [tcl_pkg::CSR_DATA_W-1:0] nibble_word(input logic [3:0] n);
      return {(($urandom_range(3) == 0) ? 12'($urandom) : 12'd0), n};
   endfunction

   function automatic logic [15:0] pick_tick_rate(input bit hurry);
      int r;
      r = $urandom_range(99);
      if (hurry || r < 10) return 16'($urandom_range(0, 4));
      if (r < 15) return 16'hFFFF;
      if (r < 30) return 16'($urandom_range(41, 1000));
      return 16'($urandom_range(5, 40));
   endfunction

   function automatic logic [3:0] pick_window_len(input bit hurry);
      if (hurry) return 4'($urandom_range(0, 4));
      if ($urandom_range(3) == 0) return 4'd15;
      return 4'($urandom_range(0, 15));
   endfunction

   task automatic csr_write(input logic [tcl_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [tcl_pkg::CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we    <= 1'b0;
      write_lock_cfg(idx, data);
   endtask

   task automatic send_touch(input logic t, input int gap);
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_touch <= t;
      do @(posedge clock); while (!req_ready);
      pending_views.push_back(apply_touch(t));
   endtask

   // drop valid and wait for every outstanding result
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_views.size() != 0) @(posedge clock);
   endtask

   task automatic send_phase(input int count);
      int   style;
      int   run_left;
      int   max_run;
      bit   no_gaps;
      logic level;
      logic t;
      style    = $urandom_range(2);
      no_gaps  = ($urandom_range(3) == 0);
      max_run  = (style == 1) ? 1 : 8;
      level    = 1'b0;
      run_left = 0;
      repeat (count) begin
         if (style == 0) begin
            t = 1'($urandom_range(1));
         end else begin
            if (run_left == 0) begin
               level    = ~level;
               run_left = $urandom_range(1, max_run);
            end
            run_left--;
            t = level;
         end
         send_touch(t, no_gaps ? 0 : pick_gap());
      end
   endtask

   task automatic shuffle_settings(input bit hurry);
      int                              writes;
      logic [tcl_pkg::CSR_INDEX_W-1:0] idx;
      logic [tcl_pkg::CSR_DATA_W-1:0]  data;
      if (hurry) begin
         csr_write(tcl_pkg::CSR_TICKS_PER_SECOND, pick_tick_rate(1'b1));
         csr_write(tcl_pkg::CSR_WINDOW_SECONDS, nibble_word(pick_window_len(1'b1)));
      end
      writes = $urandom_range(hurry ? 0 : 1, 2);
      repeat (writes) begin
         idx = 3'($urandom_range(SPARE_INDEX));
         case (idx)
            tcl_pkg::CSR_DIGIT_FIRST, tcl_pkg::CSR_DIGIT_SECOND, tcl_pkg::CSR_DIGIT_THIRD:
               data = nibble_word(4'($urandom_range(15)));
            tcl_pkg::CSR_TICKS_PER_SECOND: data = pick_tick_rate(hurry);
            tcl_pkg::CSR_WINDOW_SECONDS:   data = nibble_word(pick_window_len(hurry));
            default: begin
               idx  = 3'(SPARE_INDEX + $urandom_range(TOP_INDEX - SPARE_INDEX));
               data = 16'($urandom);
            end
         endcase
         csr_write(idx, data);
      end
   endtask

   // runs out the remaining windows, half the time with the combination set to match
   task automatic close_lock();
      logic       t;
      logic [3:0] final_taps;
      bit         match;
      csr_write(tcl_pkg::CSR_TICKS_PER_SECOND, 16'd0);
      csr_write(tcl_pkg::CSR_WINDOW_SECONDS, 16'd1);
      while (int'(win_nr) < tcl_pkg::LAST_WINDOW) begin
         send_touch(1'($urandom_range(1)), pick_gap());
         settle();
      end
      t          = 1'($urandom_range(1));
      final_taps = taps;
      if (t && !finger_held && taps != tcl_pkg::TAP_MAX)
         final_taps = taps + 1'b1;
      match = 1'($urandom_range(1));
      csr_write(tcl_pkg::CSR_DIGIT_FIRST,
                match ? {12'd0, closed_taps[0]} : nibble_word(4'($urandom_range(15))));
      csr_write(tcl_pkg::CSR_DIGIT_SECOND,
                match ? {12'd0, closed_taps[1]} : nibble_word(4'($urandom_range(15))));
      csr_write(tcl_pkg::CSR_DIGIT_THIRD,
                match ? {12'd0, final_taps} : nibble_word(4'($urandom_range(15))));
      send_touch(t, pick_gap());
      settle();
   endtask

   task automatic test_reset_values();
      // finger down at the very first sample counts as a tap
      send_touch(1'b1, 0);
      send_touch(1'b1, 0);
      send_touch(1'b0, 0);
      settle();
   endtask

   task automatic test_slow_second();
      csr_write(tcl_pkg::CSR_TICKS_PER_SECOND, 16'hFFFF);
      csr_write(tcl_pkg::CSR_WINDOW_SECONDS, 16'hFFFF);
      csr_write(tcl_pkg::CSR_DIGIT_FIRST, 16'hFFFF);
      csr_write(3'(TOP_INDEX), 16'hFFFF);
      send_touch(1'b1, 0);
      settle();
   endtask

   task automatic test_tap_saturation();
      csr_write(tcl_pkg::CSR_TICKS_PER_SECOND, 16'd4);
      for (int k = 0; k < 28; k++)
         send_touch(k[0], pick_gap());
      settle();
   endtask

   task automatic test_window_cut_short();
      // window shortened below the seconds already gone
      csr_write(tcl_pkg::CSR_WINDOW_SECONDS, 16'd3);
      send_touch(1'b0, 0);
      settle();
      csr_write(tcl_pkg::CSR_TICKS_PER_SECOND, 16'd0);
      send_touch(1'b1, 0);
      send_touch(1'b1, pick_gap());
      settle();
   endtask

   task automatic test_zero_window();
      csr_write(tcl_pkg::CSR_TICKS_PER_SECOND, 16'd1000);
      csr_write(tcl_pkg::CSR_WINDOW_SECONDS, 16'd0);
      send_touch(1'b0, 0);
      send_touch(1'b1, 0);
      settle();
   endtask

   task automatic test_random_phases();
      int  count;
      int  target;
      bit  behind;
      random_sent = 0;
      while (random_sent < RANDOM_ITEMS) begin
         settle();
         // keep the three windows running out over the span of the run
         target = (tcl_pkg::NUM_WINDOWS * random_sent) / CATCH_UP_SPAN;
         behind = (win_nr != tcl_pkg::WINDOW_FINAL) && (int'(win_nr) < target);
         if (behind && int'(win_nr) == tcl_pkg::LAST_WINDOW) begin
            close_lock();
            random_sent++;
         end else begin
            shuffle_settings(behind);
         end
         count = $urandom_range(10, 60);
         if (count > RANDOM_ITEMS - random_sent)
            count = RANDOM_ITEMS - random_sent;
         send_phase(count);
         random_sent += count;
      end
      settle();
   endtask

   task automatic test_verdict_sealed();
      if (win_nr != tcl_pkg::WINDOW_FINAL)
         close_lock();
      csr_write(tcl_pkg::CSR_DIGIT_FIRST, {12'd0, ~lock_cfg.digit[0]});
      csr_write(tcl_pkg::CSR_DIGIT_SECOND, {12'd0, ~lock_cfg.digit[1]});
      csr_write(tcl_pkg::CSR_DIGIT_THIRD, {12'd0, ~lock_cfg.digit[2]});
      csr_write(tcl_pkg::CSR_TICKS_PER_SECOND, pick_tick_rate(1'b0));
      csr_write(tcl_pkg::CSR_WINDOW_SECONDS, nibble_word(pick_window_len(1'b0)));
      send_phase(12);
      settle();
   endtask

   // result side back-pressure, with calm stretches
   always @(negedge clock) begin
      if (calm > 0) begin
         calm--;
         rsp_ready <= 1'b1;
      end else if (hold_off > 0) begin
         hold_off--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         stall_roll = $urandom_range(99);
         if (stall_roll < 2)
            calm = $urandom_range(50, 200);
         else if (stall_roll < 4)
            hold_off = $urandom_range(12, 30);
         else if (stall_roll < 30)
            hold_off = $urandom_range(1, 3);
      end
   end

   always @(posedge clock) begin : check_results
      lock_view_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_views.size() == 0) begin
            failures++;
            $display("%0t: result transaction with none expected, actual %0b %0h %0h %0b %0b",
                     $time, rsp_led_on, rsp_countdown, rsp_window_index,
                     rsp_verdict_valid, rsp_unlocked);
         end else begin
            want = pending_views.pop_front();
            compare_field("led_on", 4'(want.led_on), 4'(rsp_led_on));
            compare_field("countdown", want.countdown, rsp_countdown);
            compare_field("window_index", 4'(want.window_index), 4'(rsp_window_index));
            compare_field("verdict_valid", 4'(want.verdict_valid), 4'(rsp_verdict_valid));
            compare_field("unlocked", 4'(want.unlocked), 4'(rsp_unlocked));
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      clear_lock_model();
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_values();
      test_slow_second();
      test_tap_saturation();
      test_window_cut_short();
      test_zero_window();
      test_random_phases();
      test_verdict_sealed();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0 && pending_views.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
